// File: design/vss_pkg.sv
// Package: shared types and constants for the Vandermonde solver.
`default_nettype none
package vss_pkg;
  localparam int unsigned QW = 48;
  localparam int unsigned FW = 32;
  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD, S_DD_RD, S_DD_WT, S_DD_GO, S_DD_RUN, S_DD_WR,
    S_BS_RD, S_BS_WT, S_BS_GO, S_BS_RUN, S_BS_WR,
    S_OUT_RD, S_OUT_WT, S_OUT_HOLD
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE, OP_DIV, OP_MUL
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic dz;
    logic ovf;
  } alu_sts_t;
endpackage
`default_nettype wire

// File: design/vss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module vss_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/vss_alu.sv
// Shared bit-serial unit: Q16.32 divide (num<<32)/den and multiply (a*b)>>32.
`default_nettype none
module vss_alu import vss_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire alu_ctl_t             ctl_i,
  input  wire logic signed [QW:0]   a_i,
  input  wire logic signed [QW:0]   b_i,
  output logic signed [QW+1:0]      res_o,
  output alu_sts_t                  sts_o
);
  localparam int unsigned MW = QW + 1;
  localparam int unsigned DN = 2 * MW;
  localparam logic [DN-1:0] PCAP = {{(DN-QW-1){1'b0}}, 1'b1, {QW{1'b0}}};

  op_e               op_q, op_d;
  logic [6:0]        cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [DN-1:0]     num_q, num_d;
  logic [MW:0]       rem_q, rem_d;
  logic [MW-1:0]     den_q, den_d;
  logic [DN-1:0]     acc_q, acc_d;
  logic              over_q, over_d;
  logic [QW-1:0]     cap;
  logic [MW-1:0]     ma, mb;
  logic [MW:0]       rsh;
  logic [DN-1:0]     pmag;
  logic              busy, done_q, done_d, dz_q, dz_d;
  logic signed [QW+1:0] res_q, res_d;

  assign ma  = a_i[QW] ? MW'(-a_i) : MW'(a_i);
  assign mb  = b_i[QW] ? MW'(-b_i) : MW'(b_i);
  assign cap = neg_q ? QW'(Q_MIN) : QW'(Q_MAX);
  assign busy = (op_q != OP_NONE);
  assign rsh = {rem_q[MW-1:0], num_q[DN-1]};

  always_comb begin
    op_d = op_q; cnt_d = cnt_q; neg_d = neg_q; num_d = num_q; rem_d = rem_q;
    den_d = den_q; acc_d = acc_q; over_d = over_q; done_d = 1'b0;
    dz_d = 1'b0; res_d = res_q; pmag = '0;
    if (ctl_i.start) begin
      neg_d = a_i[QW] ^ b_i[QW];
      over_d = 1'b0;
      rem_d = '0;
      acc_d = '0;
      if (ctl_i.op == OP_DIV) begin
        num_d = DN'({ma, 32'd0});
        den_d = mb;
        cnt_d = 7'(DN);
        if (mb == '0) begin
          done_d = 1'b1; dz_d = 1'b1; res_d = '0; op_d = OP_NONE;
        end else begin
          op_d = OP_DIV;
        end
      end else begin
        num_d = DN'(mb);
        den_d = ma;
        cnt_d = 7'(MW);
        op_d = OP_MUL;
      end
    end else if (busy) begin
      cnt_d = cnt_q - 7'd1;
      if (op_q == OP_DIV) begin
        num_d = num_q << 1;
        if (rsh >= {1'b0, den_q}) begin
          rem_d = rsh - {1'b0, den_q};
          acc_d = {acc_q[DN-2:0], 1'b1};
        end else begin
          rem_d = rsh;
          acc_d = {acc_q[DN-2:0], 1'b0};
        end
        if (acc_d > DN'(cap)) over_d = 1'b1;
      end else begin
        num_d = num_q >> 1;
        if (num_q[0]) acc_d = acc_q + (DN'(den_q) << (MW - cnt_q));
      end
      if (cnt_q == 7'd1) begin
        op_d = OP_NONE;
        done_d = 1'b1;
        if (op_q == OP_DIV) begin
          if (over_d) res_d = neg_q ? (QW+2)'(Q_MIN) : (QW+2)'(Q_MAX);
          else res_d = neg_q ? -((QW+2)'(acc_d)) : (QW+2)'(acc_d);
        end else begin
          // clamp: any product this large saturates the difference anyway
          pmag = acc_d >> FW;
          if (pmag > PCAP) pmag = PCAP;
          res_d = neg_q ? -((QW+2)'(pmag)) : (QW+2)'(pmag);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE; cnt_q <= '0; done_q <= 1'b0; dz_q <= 1'b0;
    end else begin
      op_q <= op_d; cnt_q <= cnt_d; done_q <= done_d; dz_q <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    acc_q <= acc_d; over_q <= over_d; res_q <= res_d;
  end

  assign res_o = res_q;
  assign sts_o = '{done: done_q, dz: dz_q, ovf: over_q & done_q & ~dz_q};
endmodule
`default_nettype wire

// File: design/vandermonde_system_solver_unit.sv
// Top level: Bjorck-Pereyra transposed Vandermonde solver.
// Usage:
//   Input channel (node_i, rhs_i, final_req_i) loads one pair per request,
//   one cycle each. A request with final_req_i set starts the solve on the
//   stored pairs; the block drops ready until all results are taken.
//   Each divide and multiply step runs in the one shared serial unit between
//   store reads and a write-back; on equal nodes the unit skips the serial
//   loop and flags a divide fault. A solve of n pairs does n*(n-1)/2 divide
//   and n*(n-1)/2 multiply steps before the first result.
//   Results (coefficient_o, position_o, tail_o, status_o) come out in index
//   order, each read from the store after the last is taken; a stall holds
//   the result register. Status is the same on every result of a run.
//   Reset clears the pair count, fault flags and sequencer; the stores
//   hold garbage until loaded. A pair beyond MaxOrder is dropped and
//   flags saturation.
`default_nettype none
module vandermonde_system_solver_unit import vss_pkg::*; #(
  parameter int unsigned MaxOrder = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic signed [QW-1:0] node_i,
  input  wire logic signed [QW-1:0] rhs_i,
  input  wire logic                 final_req_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic signed [QW-1:0]      coefficient_o,
  output logic [4:0]                position_o,
  output logic                      tail_o,
  output logic [1:0]                status_o
);
  localparam int unsigned AW = $clog2(MaxOrder);
  localparam int unsigned CW = $clog2(MaxOrder + 1);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, k_q, k_d, j_q, j_d;
  logic [1:0]    err_q, err_d;
  logic signed [QW-1:0] t0_q, t0_d, t1_q, t1_d;
  logic signed [QW-1:0] coef_q, coef_d;
  logic [4:0]    pos_q, pos_d;
  logic          tail_q, tail_d, vo_q, vo_d;

  logic          nwe, wwe;
  logic [AW-1:0] nwa, wwa, nra, wra;
  logic [QW-1:0] nwd, wwd, nrd, wrd;
  alu_ctl_t      actl;
  alu_sts_t      asts;
  logic signed [QW:0] aa, ab;
  logic signed [QW+1:0] ares, diff;
  logic          acc_in;

  vss_ram #(.Width(QW), .Depth(MaxOrder)) u_node (
    .clk_i, .we_i(nwe), .waddr_i(nwa), .wdata_i(nwd), .raddr_i(nra), .rdata_o(nrd));
  vss_ram #(.Width(QW), .Depth(MaxOrder)) u_work (
    .clk_i, .we_i(wwe), .waddr_i(wwa), .wdata_i(wwd), .raddr_i(wra), .rdata_o(wrd));
  vss_alu u_alu (.clk_i, .rst_ni, .ctl_i(actl), .a_i(aa), .b_i(ab), .res_o(ares),
    .sts_o(asts));

  assign ready_o = (state_q == S_LOAD);
  assign acc_in  = valid_i & ready_o;
  assign diff    = (QW+2)'(t0_q) - ares;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:   if (acc_in && final_req_i) state_d = S_DD_RD;
      S_DD_RD:  state_d = S_DD_WT;
      S_DD_WT:  state_d = S_DD_GO;
      S_DD_GO:  state_d = S_DD_RUN;
      S_DD_RUN: if (asts.done) state_d = S_DD_WR;
      S_DD_WR:  state_d = S_DD_RD;
      S_BS_RD:  state_d = S_BS_WT;
      S_BS_WT:  state_d = S_BS_GO;
      S_BS_GO:  state_d = S_BS_RUN;
      S_BS_RUN: if (asts.done) state_d = S_BS_WR;
      S_BS_WR:  state_d = S_BS_RD;
      S_OUT_RD: state_d = S_OUT_WT;
      S_OUT_WT: state_d = S_OUT_HOLD;
      S_OUT_HOLD: if (vo_q && ready_i) state_d = tail_q ? S_LOAD : S_OUT_RD;
      default:  state_d = S_LOAD;
    endcase
    if (state_q == S_LOAD && acc_in && final_req_i) begin
      if (cnt_d < CW'(2)) state_d = S_OUT_RD;
    end
    if (state_q == S_DD_WR && j_q == k_q + CW'(1)) begin
      if (k_q + CW'(2) >= cnt_q) state_d = S_BS_RD;
    end
    if (state_q == S_BS_WR && j_q + CW'(2) >= cnt_q) begin
      if (k_q == '0) state_d = S_OUT_RD;
    end
  end

  // datapath and outputs
  always_comb begin
    cnt_d = cnt_q; k_d = k_q; j_d = j_q; err_d = err_q;
    t0_d = t0_q; t1_d = t1_q; coef_d = coef_q; pos_d = pos_q; tail_d = tail_q;
    vo_d = vo_q;
    nwe = 1'b0; wwe = 1'b0; nwa = AW'(cnt_q); wwa = AW'(j_q);
    nwd = node_i; wwd = rhs_i; nra = AW'(j_q); wra = AW'(j_q);
    actl = '{start: 1'b0, op: OP_NONE};
    aa = '0; ab = '0;
    unique case (state_q)
      S_LOAD: begin
        if (acc_in) begin
          if (cnt_q < CW'(MaxOrder)) begin
            nwe = 1'b1; wwe = 1'b1; wwa = AW'(cnt_q);
            cnt_d = cnt_q + CW'(1);
          end else begin
            err_d[1] = 1'b1;
          end
          if (final_req_i) begin
            k_d = '0; j_d = cnt_d - CW'(1);
            if (cnt_d < CW'(2)) j_d = '0;
          end
        end
      end
      S_DD_RD: begin
        // read work[j], node[j] then work[j-1], node[j-k-1]
        nra = AW'(j_q); wra = AW'(j_q);
      end
      S_DD_WT: begin
        t1_d = wrd; t0_d = nrd;
        nra = AW'(j_q - k_q - CW'(1)); wra = AW'(j_q - CW'(1));
      end
      S_DD_GO: begin
        actl = '{start: 1'b1, op: OP_DIV};
        aa = (QW+1)'(t1_q) - (QW+1)'($signed(wrd));
        ab = (QW+1)'(t0_q) - (QW+1)'($signed(nrd));
      end
      S_DD_RUN: begin
        if (asts.done) begin
          if (asts.dz) err_d[0] = 1'b1;
          if (asts.ovf) err_d[1] = 1'b1;
        end
      end
      S_DD_WR: begin
        wwe = 1'b1; wwa = AW'(j_q); wwd = QW'(ares);
        if (j_q == k_q + CW'(1)) begin
          k_d = k_q + CW'(1); j_d = cnt_q - CW'(1);
          if (k_q + CW'(2) >= cnt_q) begin
            k_d = cnt_q - CW'(2); j_d = cnt_q - CW'(2);
          end
        end else begin
          j_d = j_q - CW'(1);
        end
      end
      S_BS_RD: begin
        nra = AW'(k_q); wra = AW'(j_q + CW'(1));
      end
      S_BS_WT: begin
        t1_d = wrd; t0_d = nrd;
        wra = AW'(j_q);
      end
      S_BS_GO: begin
        actl = '{start: 1'b1, op: OP_MUL};
        aa = (QW+1)'(t0_q); ab = (QW+1)'(t1_q);
        t0_d = wrd;
      end
      S_BS_RUN: ;
      S_BS_WR: begin
        wwe = 1'b1; wwa = AW'(j_q);
        if (diff > (QW+2)'(Q_MAX)) begin
          wwd = Q_MAX; err_d[1] = 1'b1;
        end else if (diff < (QW+2)'(Q_MIN)) begin
          wwd = Q_MIN; err_d[1] = 1'b1;
        end else begin
          wwd = QW'(diff);
        end
        if (j_q + CW'(2) >= cnt_q) begin
          k_d = k_q - CW'(1); j_d = k_q - CW'(1);
          if (k_q == '0) j_d = '0;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_OUT_RD: begin
        wra = AW'(j_q);
      end
      S_OUT_WT: begin
        coef_d = wrd; pos_d = 5'(j_q);
        tail_d = (j_q + CW'(1) >= cnt_q);
        vo_d = 1'b1;
      end
      S_OUT_HOLD: begin
        if (vo_q && ready_i) begin
          vo_d = 1'b0; j_d = j_q + CW'(1);
          if (tail_q) begin
            cnt_d = '0; err_d = '0; j_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; cnt_q <= '0; k_q <= '0; j_q <= '0; err_q <= '0;
      vo_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; k_q <= k_d; j_q <= j_d; err_q <= err_d;
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d; t1_q <= t1_d; coef_q <= coef_d; pos_q <= pos_d; tail_q <= tail_d;
  end

  assign valid_o = vo_q;
  assign coefficient_o = coef_q;
  assign position_o = pos_q;
  assign tail_o = tail_q;
  assign status_o = err_q[0] ? ST_DIV : (err_q[1] ? ST_SAT : ST_OK);
endmodule
`default_nettype wire

// File: design/vss_checker.sv
// Port-level checker for the Vandermonde solver, bound to the top level.
`default_nettype none
module vss_checker import vss_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       ready_o,
  input wire logic       valid_o,
  input wire logic       ready_i,
  input wire logic [4:0] position_o,
  input wire logic       tail_o,
  input wire logic [1:0] status_o
);
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !ready_o) else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(position_o))
    else $error("stalled result changed");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == ST_OK || status_o == ST_DIV || status_o == ST_SAT))
    else $error("bad status code");
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i && !tail_o |=> !valid_o)
    else $error("next result came too early");
endmodule

bind vandermonde_system_solver_unit vss_checker u_vss_checker (
  .clk_i, .rst_ni, .ready_o, .valid_o, .ready_i, .position_o, .tail_o,
  .status_o);
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the Vandermonde solver: random and corner-case systems, every result checked.
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
  logic signed [47:0] coeff;
  logic [4:0]         pos;
  logic               tail;
  logic [1:0]         status;
} coeff_t;

class solve_board;
  longint      node_mem[32];
  longint      work_mem[32];
  int unsigned loaded;
  logic [1:0]  flags;
  coeff_t      pending[$];
  int          errors;
  int          checked;
  int          solves;

  function new();
    loaded = 0;
    flags = '0;
    errors = 0;
    checked = 0;
    solves = 0;
  endfunction

  function longint div_q(longint num, longint den);
    logic [127:0] m, d, q, cap;
    logic         neg;
    longint       an, ad;
    if (den == 0) begin
      flags[0] = 1'b1;
      return 0;
    end
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    m = 128'(an);
    d = 128'(ad);
    q = (m << 32) / d;
    cap = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (q > cap) begin
      flags[1] = 1'b1;
      q = cap;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function longint mul_q(longint a, longint b);
    logic [127:0] p;
    longint       ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (128'(ma) * 128'(mb)) >> 32;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function longint sat_q(longint v);
    if (v > 64'sh7FFFFFFFFFFF) begin
      flags[1] = 1'b1;
      return 64'sh7FFFFFFFFFFF;
    end
    if (v < -64'sh800000000000) begin
      flags[1] = 1'b1;
      return -64'sh800000000000;
    end
    return v;
  endfunction

  function void note_pair(logic signed [47:0] node, logic signed [47:0] rhs, logic fin);
    int     n;
    coeff_t e;
    logic [1:0] st;
    if (loaded < 32) begin
      node_mem[loaded] = longint'(node);
      work_mem[loaded] = longint'(rhs);
      loaded++;
    end else begin
      flags[1] = 1'b1;
    end
    if (!fin) return;
    n = loaded;
    for (int k = 0; k < n - 1; k++)
      for (int j = n - 1; j > k; j--)
        work_mem[j] = div_q(work_mem[j] - work_mem[j-1], node_mem[j] - node_mem[j-k-1]);
    for (int k = n - 2; k >= 0; k--)
      for (int j = k; j < n - 1; j++)
        work_mem[j] = sat_q(work_mem[j] - mul_q(node_mem[k], work_mem[j+1]));
    st = flags[0] ? vss_pkg::ST_DIV : (flags[1] ? vss_pkg::ST_SAT : vss_pkg::ST_OK);
    for (int j = 0; j < n; j++) begin
      e.coeff = work_mem[j][47:0];
      e.pos = j[4:0];
      e.tail = (j == n - 1);
      e.status = st;
      pending.push_back(e);
    end
    solves++;
    loaded = 0;
    flags = '0;
  endfunction

  function void check_coeff(coeff_t got);
    coeff_t e;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected coefficient pos=%0d value=%h", got.pos, got.coeff);
      return;
    end
    e = pending.pop_front();
    if (got !== e) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp coeff=%h pos=%0d tail=%b st=%0d, %s%h pos=%0d tail=%b st=%0d",
                 e.coeff, e.pos, e.tail, e.status, "got coeff=",
                 got.coeff, got.pos, got.tail, got.status);
    end
  endfunction
endclass

module tb_top;
  import vss_pkg::*;

  localparam int LIMIT = 6000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 valid_i = 1'b0;
  logic                 ready_o;
  logic signed [QW-1:0] node_i = '0;
  logic signed [QW-1:0] rhs_i = '0;
  logic                 final_req_i = 1'b0;
  logic                 valid_o;
  logic                 ready_i = 1'b0;
  logic signed [QW-1:0] coefficient_o;
  logic [4:0]           position_o;
  logic                 tail_o;
  logic [1:0]           status_o;

  solve_board board = new();
  bit          quiet;
  int          sent;
  longint      cycles;

  vandermonde_system_solver_unit dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic signed [47:0] rand_near(int unsigned span);
    logic signed [47:0] v;
    v = {16'($urandom_range(span)), $urandom};
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic send_pair(logic signed [47:0] node, logic signed [47:0] rhs, logic fin);
    int gap;
    gap = quiet ? 0 : $urandom_range(19);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    node_i <= node;
    rhs_i <= rhs;
    final_req_i <= fin;
    do @(posedge clk_i); while (!ready_o);
    board.note_pair(node, rhs, fin);
    sent++;
  endtask

  task automatic send_system(int n, bit wide, bit twin);
    logic signed [47:0] nd;
    logic signed [47:0] first;
    for (int i = 0; i < n; i++) begin
      nd = wide ? rand48() : rand_near(3);
      if (i == 0) first = nd;
      if (twin && i == n - 1) nd = first;
      send_pair(nd, wide ? rand48() : rand_near(255), i == n - 1);
    end
  endtask

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(19);
      if (gap > 0) begin
        ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      ready_i <= 1'b1;
      do @(posedge clk_i); while (!valid_o);
      board.check_coeff({coefficient_o, position_o, tail_o, status_o});
    end
  end

  initial begin
    sent = 0;
    quiet = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair(48'sh0001_0000_0000, Q_MAX, 1'b1);
    send_pair(Q_MIN, Q_MIN, 1'b0);
    send_pair(Q_MAX, Q_MAX, 1'b1);
    send_pair(48'sh0002_0000_0000, 48'sh0005_0000_0000, 1'b0);
    send_pair(48'sh0002_0000_0000, 48'sh0007_0000_0000, 1'b1);
    send_pair('0, 48'sh0000_8000_0000, 1'b0);
    send_pair(48'sh0001_0000_0000, -48'sh0001_0000_0000, 1'b0);
    send_pair(-48'sh0001_0000_0000, 48'sh0003_0000_0000, 1'b1);
    quiet = 1;
    send_system(32, 1'b0, 1'b0);
    quiet = 0;
    for (int i = 0; i < 33; i++)
      send_pair(rand_near(1), rand_near(15), i == 32);
    while (sent < 400) begin
      quiet = ($urandom_range(3) == 0);
      case ($urandom_range(19))
        0, 1:    send_system($urandom_range(2, 5), 1'b1, 1'b0);
        2:       send_system($urandom_range(2, 5), 1'b0, 1'b1);
        3:       send_system($urandom_range(16, 32), 1'b0, 1'b0);
        default: send_system($urandom_range(1, 6), 1'b0, 1'b0);
      endcase
    end
    valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d pairs loaded, %0d systems solved, %0d coefficients checked",
             sent, board.solves, board.checked);
    $display("systems covered singles, full stores, repeated nodes and saturating values");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
